// ===== rtl/core/lmrm_pkg.sv =====
// Shared types and constants for the landmark merge running-mean block.
// Used by lmrm_ctrl, lmrm_dp and landmark_merge_running_mean_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lmrm_pkg;

	localparam int POS_W       = 32;
	localparam int QUAT_W      = 16;
	localparam int CNT_W       = 16;
	localparam int MD_W        = 24;
	localparam int IDX_W       = 4;
	localparam int NUM_W       = 49;
	localparam int MAG_W       = 48;
	localparam int DVS_W       = 17;
	localparam int LANES       = 7;
	localparam int NPOS        = 3;
	localparam int NQUAT       = 4;
	localparam int SQ_W        = 2 * MD_W;
	localparam int SUM_W       = SQ_W + 2;
	localparam int DIV_STEPS   = MAG_W;
	localparam int SCAN_TEST   = 4;
	localparam int MAX_RESULTS = 16;
	localparam int CTR_W       = 6;

	localparam logic [MD_W-1:0]  MD_RESET = 24'd19661;
	localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_DUMP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SRC_MERGE = 2'd0,
		SRC_NEW   = 2'd1,
		SRC_DROP  = 2'd2,
		SRC_DUMP  = 2'd3
	} src_t;

	typedef struct packed {
		logic [NPOS-1:0][POS_W-1:0]   pos;
		logic [NQUAT-1:0][QUAT_W-1:0] quat;
		logic [CNT_W-1:0]             cnt;
	} entry_t;

	typedef struct packed {
		logic load_pose;
		logic mul_load;
		logic div_init;
		logic div_step;
		logic mem_we;
		logic emit;
		src_t src;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic match;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/landmark_merge_running_mean_top.sv =====
// Landmark merge table with running-mean update; top level joining lmrm_ctrl and lmrm_dp.
// Sequence: an add tests each stored entry in turn; a merge then passes through the multiply,
// divider-init, bit-serial divide and write-back states, or an append takes one state.
// Each result beat is registered. A dump alternates read and emit states; clear and the unused code stay idle.
// One item at a time: busy stays high until the last beat of the item is issued.
// Reset clears the fill level and restores the merge radius to 0.3 m; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module landmark_merge_running_mean_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Command channel: a beat is taken when start is high and busy is low.
	input  wire                                 start,
	output logic                                busy,
	input  wire  [1:0]                          operation,
	input  wire  signed [lmrm_pkg::POS_W-1:0]   pos_x,
	input  wire  signed [lmrm_pkg::POS_W-1:0]   pos_y,
	input  wire  signed [lmrm_pkg::POS_W-1:0]   pos_z,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]  quat_x,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]  quat_y,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]  quat_z,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]  quat_w,
	// Merge radius register.
	input  wire                                 cfg_we,
	input  wire  [lmrm_pkg::MD_W-1:0]           cfg_wdata,
	// Result channel: each beat is valid for exactly one cycle.
	output logic                                result_valid,
	output logic [lmrm_pkg::IDX_W-1:0]          entry_index,
	output logic                                is_new,
	output logic                                dropped,
	output logic signed [lmrm_pkg::POS_W-1:0]   out_pos_x,
	output logic signed [lmrm_pkg::POS_W-1:0]   out_pos_y,
	output logic signed [lmrm_pkg::POS_W-1:0]   out_pos_z,
	output logic signed [lmrm_pkg::QUAT_W-1:0]  out_quat_x,
	output logic signed [lmrm_pkg::QUAT_W-1:0]  out_quat_y,
	output logic signed [lmrm_pkg::QUAT_W-1:0]  out_quat_z,
	output logic signed [lmrm_pkg::QUAT_W-1:0]  out_quat_w,
	output logic [lmrm_pkg::CNT_W-1:0]          entry_count,
	output logic                                last
);

	// The fill level must hold the table depth itself; the memory address only needs
	// to reach the last entry.
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	lmrm_pkg::cmd_t      cmd;
	lmrm_pkg::stat_t     stat;
	logic [FILL_W-1:0]   addr;

	// The controller walks the table one entry at a time. The datapath reads each entry
	// from a single-port memory, runs it through a three-stage distance test and reports
	// the match. On a match all seven components are averaged by parallel lanes that share
	// one divisor, n + 1, and the updated entry is written back in the same cycle in which
	// the result beat is registered.
	lmrm_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FILL_W      (FILL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd),
		.addr      (addr)
	);

	lmrm_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_W      (ADDR_W),
		.FILL_W      (FILL_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.quat_w       (quat_w),
		.cmd          (cmd),
		.addr         (addr),
		.stat         (stat),
		.result_valid (result_valid),
		.entry_index  (entry_index),
		.is_new       (is_new),
		.dropped      (dropped),
		.out_pos_x    (out_pos_x),
		.out_pos_y    (out_pos_y),
		.out_pos_z    (out_pos_z),
		.out_quat_x   (out_quat_x),
		.out_quat_y   (out_quat_y),
		.out_quat_z   (out_quat_z),
		.out_quat_w   (out_quat_w),
		.entry_count  (entry_count),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== rtl/core/lmrm_dp.sv =====
// Datapath: entry memory, distance test pipeline, seven-lane mean divider, result registers.
// Depends on lmrm_pkg; driven by lmrm_ctrl through cmd_t and returns stat_t.
`timescale 1ns / 1ps
`default_nettype none
module lmrm_dp #(
	parameter int TABLE_DEPTH = 16,
	parameter int ADDR_W      = 4,
	parameter int FILL_W      = 5
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       cfg_we,
	input  wire  [lmrm_pkg::MD_W-1:0]                 cfg_wdata,
	input  wire  signed [lmrm_pkg::POS_W-1:0]         pos_x,
	input  wire  signed [lmrm_pkg::POS_W-1:0]         pos_y,
	input  wire  signed [lmrm_pkg::POS_W-1:0]         pos_z,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]        quat_x,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]        quat_y,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]        quat_z,
	input  wire  signed [lmrm_pkg::QUAT_W-1:0]        quat_w,
	input  lmrm_pkg::cmd_t                            cmd,
	input  wire  [FILL_W-1:0]                         addr,
	output lmrm_pkg::stat_t                           stat,
	output logic                                      result_valid,
	output logic [lmrm_pkg::IDX_W-1:0]                entry_index,
	output logic                                      is_new,
	output logic                                      dropped,
	output logic signed [lmrm_pkg::POS_W-1:0]         out_pos_x,
	output logic signed [lmrm_pkg::POS_W-1:0]         out_pos_y,
	output logic signed [lmrm_pkg::POS_W-1:0]         out_pos_z,
	output logic signed [lmrm_pkg::QUAT_W-1:0]        out_quat_x,
	output logic signed [lmrm_pkg::QUAT_W-1:0]        out_quat_y,
	output logic signed [lmrm_pkg::QUAT_W-1:0]        out_quat_z,
	output logic signed [lmrm_pkg::QUAT_W-1:0]        out_quat_w,
	output logic [lmrm_pkg::CNT_W-1:0]                entry_count,
	output logic                                      last
);

	lmrm_pkg::entry_t mem_q [TABLE_DEPTH];
	lmrm_pkg::entry_t rd_q;
	lmrm_pkg::entry_t pose_q;
	lmrm_pkg::entry_t merge_c;
	lmrm_pkg::entry_t new_c;
	lmrm_pkg::entry_t wr_c;
	lmrm_pkg::entry_t emit_c;
	logic [lmrm_pkg::MD_W-1:0] md_q;

	// Distance test pipeline.
	logic [lmrm_pkg::POS_W:0]                 ad_c [lmrm_pkg::NPOS];
	logic                                     ok_c;
	logic [lmrm_pkg::MD_W-1:0]                ad_s1 [lmrm_pkg::NPOS];
	logic                                     ok_s1;
	logic [lmrm_pkg::SQ_W-1:0]                sq_s2 [lmrm_pkg::NPOS];
	logic [lmrm_pkg::SQ_W-1:0]                mdsq_s2;
	logic                                     ok_s2;
	logic [lmrm_pkg::SUM_W-1:0]               sum_c;
	logic                                     match_s3;

	// Mean lanes.
	logic signed [lmrm_pkg::POS_W-1:0]        old_c [lmrm_pkg::LANES];
	logic signed [lmrm_pkg::POS_W-1:0]        nw_c [lmrm_pkg::LANES];
	logic signed [lmrm_pkg::NUM_W-1:0]        num_c [lmrm_pkg::LANES];
	logic signed [lmrm_pkg::NUM_W-1:0]        num_s1 [lmrm_pkg::LANES];
	logic [lmrm_pkg::MAG_W-1:0]               mag_q [lmrm_pkg::LANES];
	logic [lmrm_pkg::DVS_W-1:0]               rem_q [lmrm_pkg::LANES];
	logic                                     sgn_q [lmrm_pkg::LANES];
	logic [lmrm_pkg::DVS_W-1:0]               dvs_q;
	logic [lmrm_pkg::MAG_W-1:0]               qm_c [lmrm_pkg::LANES];
	logic [lmrm_pkg::POS_W-1:0]               quot_c [lmrm_pkg::LANES];
	logic signed [lmrm_pkg::NUM_W-1:0]        cnt_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q <= lmrm_pkg::MD_RESET;
		end else if (cfg_we) begin
			md_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pose) begin
			pose_q.pos[0]  <= pos_x;
			pose_q.pos[1]  <= pos_y;
			pose_q.pos[2]  <= pos_z;
			pose_q.quat[0] <= quat_x;
			pose_q.quat[1] <= quat_y;
			pose_q.quat[2] <= quat_z;
			pose_q.quat[3] <= quat_w;
			pose_q.cnt     <= lmrm_pkg::CNT_W'(1);
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[addr[ADDR_W-1:0]] <= wr_c;
		end
		rd_q <= mem_q[addr[ADDR_W-1:0]];
	end

	always_comb begin
		ok_c = 1'b1;
		for (int k = 0; k < lmrm_pkg::NPOS; k++) begin
			logic signed [lmrm_pkg::POS_W:0] d;
			d = $signed({pose_q.pos[k][lmrm_pkg::POS_W-1], pose_q.pos[k]})
			  - $signed({rd_q.pos[k][lmrm_pkg::POS_W-1], rd_q.pos[k]});
			ad_c[k] = d[lmrm_pkg::POS_W] ? (~d + 1'b1) : d;
			if (ad_c[k] >= (lmrm_pkg::POS_W + 1)'(md_q)) begin
				ok_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < lmrm_pkg::NPOS; k++) begin
			ad_s1[k] <= ad_c[k][lmrm_pkg::MD_W-1:0];
			sq_s2[k] <= lmrm_pkg::SQ_W'(ad_s1[k]) * lmrm_pkg::SQ_W'(ad_s1[k]);
		end
		ok_s1    <= ok_c;
		ok_s2    <= ok_s1;
		mdsq_s2  <= lmrm_pkg::SQ_W'(md_q) * lmrm_pkg::SQ_W'(md_q);
		match_s3 <= ok_s2 && (sum_c < lmrm_pkg::SUM_W'(mdsq_s2));
	end

	assign sum_c = lmrm_pkg::SUM_W'(sq_s2[0]) + lmrm_pkg::SUM_W'(sq_s2[1])
	             + lmrm_pkg::SUM_W'(sq_s2[2]);
	assign stat.match = match_s3;

	// Numerators new + old * n, one lane per component.
	assign cnt_s = lmrm_pkg::NUM_W'($signed({1'b0, rd_q.cnt}));

	always_comb begin
		for (int k = 0; k < lmrm_pkg::LANES; k++) begin
			if (k < lmrm_pkg::NPOS) begin
				old_c[k] = rd_q.pos[k];
				nw_c[k]  = pose_q.pos[k];
			end else begin
				old_c[k] = lmrm_pkg::POS_W'($signed(rd_q.quat[k - lmrm_pkg::NPOS]));
				nw_c[k]  = lmrm_pkg::POS_W'($signed(pose_q.quat[k - lmrm_pkg::NPOS]));
			end
			num_c[k] = lmrm_pkg::NUM_W'(nw_c[k]) + lmrm_pkg::NUM_W'(old_c[k]) * cnt_s;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			for (int k = 0; k < lmrm_pkg::LANES; k++) begin
				num_s1[k] <= num_c[k];
			end
			dvs_q <= lmrm_pkg::DVS_W'(rd_q.cnt) + 1'b1;
		end
	end

	// Restoring divider: one quotient bit per lane per cycle, sign applied at the end.
	always_ff @(posedge clk) begin
		for (int k = 0; k < lmrm_pkg::LANES; k++) begin
			logic [lmrm_pkg::NUM_W-1:0] neg;
			logic [lmrm_pkg::DVS_W:0]   rsh;
			neg = ~num_s1[k] + 1'b1;
			rsh = {rem_q[k], mag_q[k][lmrm_pkg::MAG_W-1]};
			if (cmd.div_init) begin
				sgn_q[k] <= num_s1[k][lmrm_pkg::NUM_W-1];
				mag_q[k] <= num_s1[k][lmrm_pkg::NUM_W-1] ? neg[lmrm_pkg::MAG_W-1:0]
				                                         : num_s1[k][lmrm_pkg::MAG_W-1:0];
				rem_q[k] <= '0;
			end else if (cmd.div_step) begin
				if (rsh >= {1'b0, dvs_q}) begin
					rem_q[k] <= lmrm_pkg::DVS_W'(rsh - {1'b0, dvs_q});
					mag_q[k] <= {mag_q[k][lmrm_pkg::MAG_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= rsh[lmrm_pkg::DVS_W-1:0];
					mag_q[k] <= {mag_q[k][lmrm_pkg::MAG_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < lmrm_pkg::LANES; k++) begin
			qm_c[k]   = sgn_q[k] ? (~mag_q[k] + 1'b1) : mag_q[k];
			quot_c[k] = qm_c[k][lmrm_pkg::POS_W-1:0];
		end
		for (int k = 0; k < lmrm_pkg::NPOS; k++) begin
			merge_c.pos[k] = quot_c[k];
		end
		for (int k = 0; k < lmrm_pkg::NQUAT; k++) begin
			merge_c.quat[k] = quot_c[k + lmrm_pkg::NPOS][lmrm_pkg::QUAT_W-1:0];
		end
		merge_c.cnt = (rd_q.cnt == lmrm_pkg::CNT_MAX) ? rd_q.cnt : rd_q.cnt + 1'b1;
		new_c       = pose_q;
		wr_c        = (cmd.src == lmrm_pkg::SRC_MERGE) ? merge_c : new_c;
		case (cmd.src)
			lmrm_pkg::SRC_MERGE: emit_c = merge_c;
			lmrm_pkg::SRC_NEW:   emit_c = new_c;
			lmrm_pkg::SRC_DUMP:  emit_c = rd_q;
			default:             emit_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			entry_index <= (cmd.src == lmrm_pkg::SRC_DROP) ? '0 : lmrm_pkg::IDX_W'(addr);
			is_new      <= (cmd.src == lmrm_pkg::SRC_NEW);
			dropped     <= (cmd.src == lmrm_pkg::SRC_DROP);
			out_pos_x   <= emit_c.pos[0];
			out_pos_y   <= emit_c.pos[1];
			out_pos_z   <= emit_c.pos[2];
			out_quat_x  <= emit_c.quat[0];
			out_quat_y  <= emit_c.quat[1];
			out_quat_z  <= emit_c.quat[2];
			out_quat_w  <= emit_c.quat[3];
			entry_count <= emit_c.cnt;
			last        <= cmd.last;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lmrm_ctrl.sv =====
// Controller state machine: scans, merges, appends and dumps table entries, and clears the fill level.
// Depends on lmrm_pkg; drives lmrm_dp through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module lmrm_ctrl #(
	parameter int TABLE_DEPTH = 16,
	parameter int FILL_W      = 5
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [1:0]            operation,
	input  lmrm_pkg::stat_t       stat,
	output logic                  busy,
	output lmrm_pkg::cmd_t        cmd,
	output logic [FILL_W-1:0]     addr
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SCAN   = 9'b000000010,
		ST_MUL    = 9'b000000100,
		ST_DINIT  = 9'b000001000,
		ST_DIV    = 9'b000010000,
		ST_WRM    = 9'b000100000,
		ST_APPEND = 9'b001000000,
		ST_DRD    = 9'b010000000,
		ST_DEM    = 9'b100000000
	} state_t;

	state_t                       state_q, state_d;
	logic [FILL_W-1:0]            idx_q, idx_d;
	logic [FILL_W-1:0]            fill_q, fill_d;
	logic [lmrm_pkg::CTR_W-1:0]   cnt_q, cnt_d;
	logic [FILL_W-1:0]            idx_inc;
	logic [FILL_W-1:0]            dump_end;
	logic                         dump_last;

	assign idx_inc   = idx_q + 1'b1;
	assign dump_end  = (8'(fill_q) > 8'(lmrm_pkg::MAX_RESULTS))
	                 ? FILL_W'(lmrm_pkg::MAX_RESULTS) : fill_q;
	assign dump_last = (idx_inc == dump_end);
	assign busy      = (state_q != ST_IDLE);
	assign addr      = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		fill_d  = fill_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.src = lmrm_pkg::SRC_MERGE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_pose = 1'b1;
					idx_d = '0;
					cnt_d = '0;
					case (lmrm_pkg::op_t'(operation))
						lmrm_pkg::OP_CLEAR: fill_d = '0;
						lmrm_pkg::OP_DUMP: begin
							if (fill_q != '0) state_d = ST_DRD;
						end
						lmrm_pkg::OP_ADD: begin
							state_d = (fill_q == '0) ? ST_APPEND : ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lmrm_pkg::CTR_W'(lmrm_pkg::SCAN_TEST)) begin
					cnt_d = '0;
					if (stat.match) begin
						state_d = ST_MUL;
					end else begin
						idx_d = idx_inc;
						if (idx_inc == fill_q) state_d = ST_APPEND;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lmrm_pkg::CTR_W'(lmrm_pkg::DIV_STEPS - 1)) begin
					state_d = ST_WRM;
				end
			end
			ST_WRM: begin
				cmd.mem_we = 1'b1;
				cmd.emit   = 1'b1;
				cmd.last   = 1'b1;
				cmd.src    = lmrm_pkg::SRC_MERGE;
				state_d    = ST_IDLE;
			end
			ST_APPEND: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				if (fill_q == FILL_W'(TABLE_DEPTH)) begin
					cmd.src = lmrm_pkg::SRC_DROP;
				end else begin
					cmd.src    = lmrm_pkg::SRC_NEW;
					cmd.mem_we = 1'b1;
					fill_d     = fill_q + 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_DRD: begin
				state_d = ST_DEM;
			end
			ST_DEM: begin
				cmd.emit = 1'b1;
				cmd.src  = lmrm_pkg::SRC_DUMP;
				cmd.last = dump_last;
				idx_d    = idx_inc;
				state_d  = dump_last ? ST_IDLE : ST_DRD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fill_q  <= fill_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire
